[design/keypad_code_lock_top_macros.svh]
// ----------------------------------------------------------------------------
// Keypad code lock assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_TOP_MACROS_SVH
`define KEYPAD_CODE_LOCK_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define KCL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/kcl_pkg.sv]
// ----------------------------------------------------------------------------
// kcl_pkg
// Types, codes and widths shared by the keypad code lock modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

	localparam int unsigned DIGIT_W       = 4;
	localparam int unsigned CODE_SLOTS    = 8;
	localparam int unsigned CODE_W        = DIGIT_W * CODE_SLOTS;
	localparam int unsigned LEN_W         = 4;
	localparam int unsigned ATTEMPT_W     = 8;
	localparam int unsigned MAX_DIGITS_DEF = 8;
	localparam int unsigned CFG_IDX_W     = 1;

	typedef enum logic [1:0] {
		OP_DIGIT     = 2'd0,
		OP_BACKSPACE = 2'd1,
		OP_CLEAR     = 2'd2,
		OP_ENTER     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		SND_NONE    = 3'd0,
		SND_BEEP    = 3'd1,
		SND_INVALID = 3'd2,
		SND_SUCCESS = 3'd3,
		SND_ERROR   = 3'd4
	} sound_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CODE_DIGITS = 1'b0,
		CFG_CODE_LENGTH = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic                 accepted;
		sound_t               sound;
		logic [LEN_W-1:0]     entry_length;
		logic [CODE_W-1:0]    entry_value;
		logic [ATTEMPT_W-1:0] failed_attempts;
	} result_t;

endpackage

`default_nettype wire

[design/kcl_step.sv]
// ----------------------------------------------------------------------------
// kcl_step
// Next-state and result logic for one key event of the code lock.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_step #(
	parameter int unsigned SLOTS = kcl_pkg::CODE_SLOTS
) (
	input  logic [SLOTS-1:0][kcl_pkg::DIGIT_W-1:0] entry,
	input  logic [kcl_pkg::LEN_W-1:0]              count,
	input  logic [kcl_pkg::ATTEMPT_W-1:0]          attempts,
	input  logic [1:0]                             op,
	input  logic [kcl_pkg::DIGIT_W-1:0]            digit,
	input  logic [kcl_pkg::CODE_W-1:0]             code_digits,
	input  logic [kcl_pkg::LEN_W-1:0]              code_length,
	output logic [SLOTS-1:0][kcl_pkg::DIGIT_W-1:0] next_entry,
	output logic [kcl_pkg::LEN_W-1:0]              next_count,
	output logic [kcl_pkg::ATTEMPT_W-1:0]          next_attempts,
	output kcl_pkg::result_t                       result
);
	import kcl_pkg::*;

	localparam logic [LEN_W-1:0] SLOTS_L = LEN_W'(SLOTS);

	logic [LEN_W-1:0]  eff_len;
	logic              match;
	logic              accepted;
	sound_t            sound;
	logic [CODE_W-1:0] packed_value;

	// The usable code length is capped by the number of entry slots.
	assign eff_len = (code_length > SLOTS_L) ? SLOTS_L : code_length;

	always_comb begin
		match = (count == eff_len);
		for (int i = 0; i < SLOTS; i++) begin
			if ((LEN_W'(i) < eff_len) &&
			    (entry[i] != code_digits[DIGIT_W*i +: DIGIT_W])) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		next_entry    = entry;
		next_count    = count;
		next_attempts = attempts;
		accepted      = 1'b0;
		sound         = SND_INVALID;
		unique case (op_t'(op))
			OP_DIGIT: begin
				if (count < eff_len) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (LEN_W'(i) == count) begin
							next_entry[i] = digit;
						end
					end
					next_count = count + 1'b1;
					accepted   = 1'b1;
					sound      = SND_BEEP;
				end
			end
			OP_BACKSPACE: begin
				if (count != '0) begin
					next_count = count - 1'b1;
					for (int i = 0; i < SLOTS; i++) begin
						if (LEN_W'(i) == next_count) begin
							next_entry[i] = '0;
						end
					end
					accepted = 1'b1;
					sound    = SND_BEEP;
				end
			end
			OP_CLEAR: begin
				next_entry = '0;
				next_count = '0;
				accepted   = 1'b1;
				sound      = SND_BEEP;
			end
			OP_ENTER: begin
				if (count == '0) begin
					sound = SND_INVALID;
				end else if (match) begin
					next_attempts = '0;
					accepted      = 1'b1;
					sound         = SND_SUCCESS;
				end else begin
					next_attempts = attempts + 1'b1;
					sound         = SND_ERROR;
				end
			end
		endcase
	end

	// Slots beyond the configured depth read as zero nibbles.
	always_comb begin
		packed_value = '0;
		for (int i = 0; i < SLOTS; i++) begin
			packed_value[DIGIT_W*i +: DIGIT_W] = next_entry[i];
		end
	end

	assign result.accepted        = accepted;
	assign result.sound           = sound;
	assign result.entry_length    = next_count;
	assign result.entry_value     = packed_value;
	assign result.failed_attempts = next_attempts;

endmodule

`default_nettype wire

[design/keypad_code_lock_top.sv]
// ----------------------------------------------------------------------------
// keypad_code_lock_top
// Keypad code lock: digit entry, backspace, clear and code check on enter.
// ----------------------------------------------------------------------------
// Results are registered in the result register, or in the skid on an output stall.
// Throughput: one key event per cycle while the skid is empty; the entry state
// updates on each transfer. A two-entry output buffer (result register and skid)
// keeps input open while the output stalls, until the skid fills. Reset clears the
// entry, counters and buffer valid flags, sets the code to zero and the code length to four.
`default_nettype none

module keypad_code_lock_top #(
	parameter int unsigned MAX_DIGITS = kcl_pkg::MAX_DIGITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          op,
	input  logic [kcl_pkg::DIGIT_W-1:0]         digit,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                accepted,
	output logic [2:0]                          sound,
	output logic [kcl_pkg::LEN_W-1:0]           entry_length,
	output logic [kcl_pkg::CODE_W-1:0]          entry_value,
	output logic [kcl_pkg::ATTEMPT_W-1:0]       failed_attempts,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kcl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kcl_pkg::CODE_W-1:0]          cfg_data
);
	import kcl_pkg::*;

	localparam int unsigned SLOTS = (MAX_DIGITS < CODE_SLOTS) ? MAX_DIGITS : CODE_SLOTS;

	logic [SLOTS-1:0][DIGIT_W-1:0] entry_q;
	logic [LEN_W-1:0]              count_q;
	logic [ATTEMPT_W-1:0]          attempts_q;
	logic [CODE_W-1:0]             code_digits_q;
	logic [LEN_W-1:0]              code_length_q;

	logic [SLOTS-1:0][DIGIT_W-1:0] next_entry;
	logic [LEN_W-1:0]              next_count;
	logic [ATTEMPT_W-1:0]          next_attempts;
	result_t                       step_res;

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    in_xfer;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign in_xfer   = in_valid && in_ready;

	kcl_step #(
		.SLOTS(SLOTS)
	) u_step (
		.entry        (entry_q),
		.count        (count_q),
		.attempts     (attempts_q),
		.op           (op),
		.digit        (digit),
		.code_digits  (code_digits_q),
		.code_length  (code_length_q),
		.next_entry   (next_entry),
		.next_count   (next_count),
		.next_attempts(next_attempts),
		.result       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_digits_q <= '0;
			code_length_q <= LEN_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CODE_DIGITS: code_digits_q <= cfg_data;
				CFG_CODE_LENGTH: code_length_q <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q    <= '0;
			count_q    <= '0;
			attempts_q <= '0;
		end else if (in_xfer) begin
			entry_q    <= next_entry;
			count_q    <= next_count;
			attempts_q <= next_attempts;
		end
	end

	// The skid entry holds a result that arrived while the output stalled;
	// it drains first, and input is held off until it has.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q || in_xfer;
			skid_valid_q <= 1'b0;
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : step_res;
		end else if (in_xfer) begin
			skid_q <= step_res;
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = out_q.accepted;
	assign sound           = 3'(out_q.sound);
	assign entry_length    = out_q.entry_length;
	assign entry_value     = out_q.entry_value;
	assign failed_attempts = out_q.failed_attempts;

endmodule

`default_nettype wire

[design/kcl_checker.sv]
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level assertions for the keypad code lock, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keypad_code_lock_top_macros.svh"

module kcl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          accepted,
	input logic [2:0]                    sound,
	input logic [kcl_pkg::LEN_W-1:0]     entry_length,
	input logic [kcl_pkg::CODE_W-1:0]    entry_value,
	input logic [kcl_pkg::ATTEMPT_W-1:0] failed_attempts
);
	import kcl_pkg::*;

	// A stalled result must hold until its transfer.
	`KCL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(accepted) && $stable(sound) && $stable(entry_length) && $stable(entry_value) && $stable(failed_attempts), "result changed while stalled")

	// An accepted event only ever beeps or plays the success melody.
	`KCL_ASSERT_IMPL(a_acc_sound, out_valid && accepted, sound == SND_BEEP || sound == SND_SUCCESS, "accepted event with wrong sound")

	// A refused event is either invalid or a wrong code.
	`KCL_ASSERT_IMPL(a_rej_sound, out_valid && !accepted, sound == SND_INVALID || sound == SND_ERROR, "refused event with wrong sound")

	// A successful enter clears the failed attempt count.
	`KCL_ASSERT_IMPL(a_success_clear, out_valid && sound == SND_SUCCESS, failed_attempts == '0, "success left failed attempts set")

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (.*);

`default_nettype wire
